/* hw/rtl/sabht_pkg.sv */
`timescale 1ns / 1ps

package sabht_pkg;

  localparam int unsigned PC_W   = 32;
  localparam int unsigned HIST_W = 12;

  typedef struct packed {
    logic              action;
    logic [PC_W-1:0]   pc;
    logic [HIST_W-1:0] new_history;
  } req_t;

  typedef struct packed {
    logic [HIST_W-1:0] history;
    logic              hit;
  } rsp_t;

  // Request action codes
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

endpackage

/* hw/rtl/sabht_if.sv */
`timescale 1ns / 1ps

interface sabht_req_if import sabht_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sabht_rsp_if import sabht_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sabht_ram.sv */
`timescale 1ns / 1ps

module sabht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/set_assoc_branch_history_table_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Beat when
// req_i     in   action, pc[31:0], new_history    req_i.valid & req_i.ready
// rsp_o     out  history[11:0], hit               rsp_o.valid & rsp_o.ready
//
// One request per cycle sustained while rsp_o is ready; the set row is read from
// the RAM into the update stage, which does compare/update/write back and loads
// the response register that drives rsp_o.
// Accesses to the set written last are served from a forwarding register.
// After reset a clearing pass writes one set row per cycle, covering all
// ENTRIES/WAYS sets (128 at defaults); requests are held off until it finishes.
// A stalled response holds the update stage, which then holds the request side.

module set_assoc_branch_history_table_core import sabht_pkg::*; #(
  parameter int unsigned ENTRIES  = 512,
  parameter int unsigned WAYS     = 4,
  parameter int unsigned HIST_LEN = 12,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sabht_req_if.sink   req_i,
  sabht_rsp_if.source rsp_o
);

  localparam int unsigned NSETS  = (ENTRIES / WAYS > 0) ? (ENTRIES / WAYS) : 1;
  localparam int unsigned SB     = $clog2(NSETS);
  localparam int unsigned SIW    = (SB > 0) ? SB : 1;
  localparam int unsigned VW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned HW     = (HIST_LEN < HIST_W) ? HIST_LEN : HIST_W;
  localparam int unsigned TW     = PC_W - 2 - SB;
  localparam int unsigned LINE_W = 1 + TW + HW;
  localparam int unsigned ROW_W  = WAYS * LINE_W + VW;
  localparam int unsigned TAG_LO = HW;
  localparam int unsigned VLD_B  = HW + TW;
  localparam logic [PC_W-1:0] ADDR_MASK =
    (ADDR_BITS >= PC_W) ? {PC_W{1'b1}} : PC_W'((64'd1 << ADDR_BITS) - 64'd1);

  // request decode
  logic [PC_W-1:0] pc_m;
  logic [SIW-1:0]  req_set;
  logic [TW-1:0]   req_tag;

  assign pc_m    = req_i.data.pc & ADDR_MASK;
  assign req_tag = pc_m[PC_W-1 -: TW];

  if (SB > 0) begin : g_set
    assign req_set = pc_m[2 +: SB] & SIW'(NSETS - 1);
  end else begin : g_one_set
    assign req_set = '0;
  end

  // clearing pass
  logic           clearing_q, clearing_d;
  logic [SIW-1:0] clr_cnt_q, clr_cnt_d;

  // update stage
  logic           s1_vld_q, s1_vld_d;
  logic           s1_action_q;
  logic [TW-1:0]  s1_tag_q;
  logic [SIW-1:0] s1_set_q;
  logic [HW-1:0]  s1_nh_q;
  logic           s1_fire;

  // forwarding of the last row written by the update stage
  logic             fwd_vld_q, fwd_vld_d;
  logic [SIW-1:0]   fwd_set_q;
  logic [ROW_W-1:0] fwd_row_q;

  // response register
  logic              out_vld_q, out_vld_d;
  logic [HIST_W-1:0] out_hist_q;
  logic              out_hit_q;

  logic             req_beat;
  logic [ROW_W-1:0] rd_row, row_cur, row_new;
  logic             ram_we;
  logic [SIW-1:0]   ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] clr_row;

  logic [WAYS-1:0]  way_hit;
  logic             hit;
  logic [VW-1:0]    hit_way, victim, victim_eff, victim_nxt, sel_way;
  logic [HW-1:0]    sel_hist;

  assign s1_fire     = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !clearing_q && (!s1_vld_q || s1_fire);
  assign req_beat    = req_i.valid && req_i.ready;

  always_comb begin
    clr_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*LINE_W +: HW] = {HW{1'b1}};
    end
  end

  assign row_cur = (fwd_vld_q && (fwd_set_q == s1_set_q)) ? fwd_row_q : rd_row;

  always_comb begin
    logic [LINE_W-1:0] line;
    for (int w = 0; w < WAYS; w++) begin
      line       = row_cur[w*LINE_W +: LINE_W];
      way_hit[w] = line[VLD_B] && (line[TAG_LO +: TW] == s1_tag_q);
    end
    hit     = |way_hit;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_hit[w]) begin
        hit_way = VW'(w);
      end
    end
  end

  always_comb begin
    victim     = row_cur[WAYS*LINE_W +: VW];
    victim_eff = (32'(victim) >= WAYS) ? '0 : victim;
    victim_nxt = (32'(victim_eff) == WAYS - 1) ? '0 : victim_eff + VW'(1);
    sel_way    = hit ? hit_way : victim_eff;
  end

  always_comb begin
    row_new  = row_cur;
    sel_hist = '0;
    if (!hit) begin
      row_new[WAYS*LINE_W +: VW] = victim_nxt;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (VW'(w) == sel_way) begin
        if (!hit) begin
          row_new[w*LINE_W + VLD_B]          = 1'b1;
          row_new[w*LINE_W + TAG_LO +: TW]   = s1_tag_q;
        end
        if (s1_action_q == ACT_WRITE) begin
          row_new[w*LINE_W +: HW] = s1_nh_q;
        end
        sel_hist = row_new[w*LINE_W +: HW];
      end
    end
  end

  always_comb begin
    ram_we    = clearing_q || s1_fire;
    ram_waddr = clearing_q ? clr_cnt_q : s1_set_q;
    ram_wdata = clearing_q ? clr_row : row_new;
  end

  sabht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (req_beat),
    .raddr_i (req_set),
    .rdata_o (rd_row)
  );

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + SIW'(1);
      if (32'(clr_cnt_q) == NSETS - 1) begin
        clearing_d = 1'b0;
      end
    end
    s1_vld_d  = req_beat || (s1_vld_q && !s1_fire);
    fwd_vld_d = fwd_vld_q || s1_fire;
    out_vld_d = s1_fire || (out_vld_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_vld_q   <= s1_vld_d;
      fwd_vld_q  <= fwd_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_beat) begin
      s1_action_q <= req_i.data.action;
      s1_tag_q    <= req_tag;
      s1_set_q    <= req_set;
      s1_nh_q     <= HW'(req_i.data.new_history);
    end
    if (s1_fire) begin
      fwd_set_q  <= s1_set_q;
      fwd_row_q  <= row_new;
      out_hist_q <= HIST_W'(sel_hist);
      out_hit_q  <= hit;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.data.history = out_hist_q;
  assign rsp_o.data.hit     = out_hit_q;

  a_no_update_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing_q |-> !s1_vld_q
  ) else $error("update stage active during clearing pass");

  a_beat_fills_stage: assert property (
    @(posedge clk_i) disable iff (!rst_ni) req_beat |=> s1_vld_q
  ) else $error("accepted request lost before update stage");

  a_stall_holds_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_fire) |=> (s1_vld_q && $stable(s1_set_q))
  ) else $error("stalled update stage changed");

  a_fwd_tracks_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (fwd_vld_q && (fwd_set_q == $past(s1_set_q)))
  ) else $error("forwarding register missed a write back");

  a_fire_fills_rsp: assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_fire |=> out_vld_q
  ) else $error("response dropped");

endmodule
